FILE: rtl/core/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// character codes of the alphabet edges, sextet constants and the records
// passed between the decode step and the top level
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;  // 'z'

  // digits: code - ('0' - 52), i.e. code + 4 mod 256
  localparam logic [7:0] DIGIT_ADD    = 8'd4;
  // lower case: code - ('a' - 26)
  localparam logic [7:0] LOWER_SUB    = 8'd71;

  localparam logic [7:0] SEXTET_PLUS  = 8'd62;
  localparam logic [7:0] SEXTET_SLASH = 8'd63;

  // decoder state carried between items
  typedef struct packed {
    logic [2:0][7:0] held;   // held sextet codes, all 8 bits kept
    logic [1:0]      cnt;    // number of held sextets
    logic            pad;    // padding sign seen
    logic            bad;    // character above 'z' seen
  } b64d_state_t;

  // results caused by one item
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n_res;     // 1 to 3 results
    logic            has_bytes; // 0: one flag-only result
    logic            fin;
    logic            stray;
    logic            dangling;
    logic            bad;
  } b64d_group_t;

endpackage

FILE: rtl/core/b64d_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_step: decode step for one character
// maps the character to a sextet, updates the held state and forms the
// result group for the item
// ----------------------------------------------------------------------------
module b64d_step (
  input  b64d_pkg::b64d_state_t st,
  input  logic [7:0]            char_code,
  input  logic                  final_char,
  output b64d_pkg::b64d_state_t st_next,
  output b64d_pkg::b64d_group_t grp,
  output logic                  produces
);

  logic [7:0]      sextet;
  logic            bad_char;
  logic            full;
  logic [2:0][7:0] h;

  // mapping chain, first match wins
  always_comb begin
    bad_char = 1'b0;
    if (char_code == b64d_pkg::CHAR_PLUS) begin
      sextet = b64d_pkg::SEXTET_PLUS;
    end else if (char_code == b64d_pkg::CHAR_SLASH) begin
      sextet = b64d_pkg::SEXTET_SLASH;
    end else if (char_code <= b64d_pkg::CHAR_NINE) begin
      sextet = char_code + b64d_pkg::DIGIT_ADD;
    end else if (char_code <= b64d_pkg::CHAR_UPPER_Z) begin
      sextet = char_code - b64d_pkg::CHAR_UPPER_A;
    end else if (char_code <= b64d_pkg::CHAR_LOWER_Z) begin
      sextet = char_code - b64d_pkg::LOWER_SUB;
    end else begin
      sextet   = 8'd0;
      bad_char = 1'b1;
    end
  end

  always_comb begin
    st_next = st;
    full    = 1'b0;
    if (!st.pad) begin
      if (char_code == b64d_pkg::CHAR_PAD) begin
        st_next.pad = 1'b1;
      end else begin
        if (bad_char) st_next.bad = 1'b1;
        if (st.cnt == 2'd3) begin
          full        = 1'b1;
          st_next.cnt = 2'd0;
        end else begin
          st_next.held[st.cnt] = sextet;
          st_next.cnt          = st.cnt + 2'd1;
        end
      end
    end

    h = st_next.held;
    grp.bytes[0]  = {h[0][5:0], 2'b00} | {4'b0000, h[1][7:4]};
    grp.bytes[1]  = {h[1][3:0], 4'b0000} | {2'b00, h[2][7:2]};
    grp.bytes[2]  = {h[2][1:0], 6'b000000} | sextet;
    grp.fin       = final_char;
    grp.bad       = st_next.bad;
    grp.n_res     = 2'd1;
    grp.has_bytes = 1'b0;
    grp.stray     = 1'b0;
    grp.dangling  = 1'b0;

    if (full) begin
      grp.n_res     = 2'd3;
      grp.has_bytes = 1'b1;
    end else if (final_char) begin
      unique case (st_next.cnt)
        2'd1: grp.dangling = 1'b1;
        2'd2: begin
          grp.has_bytes = 1'b1;
          grp.stray     = |h[1][3:0];
        end
        2'd3: begin
          grp.n_res     = 2'd2;
          grp.has_bytes = 1'b1;
          grp.stray     = |h[2][1:0];
        end
        default: grp.n_res = 2'd1;
      endcase
    end

    produces = full | final_char;

    // the final character returns the decoder to its reset state
    if (final_char) st_next = '0;
  end

endmodule

FILE: rtl/core/base64_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 text to byte decoder
// one character per item in, decoded bytes out one per result item
// ----------------------------------------------------------------------------
// A character is taken into an input register and decoded in the next cycle
// against the held sextets; every fourth mapped character yields three
// results, the final character yields its tail bytes (or one flag-only result
// with byte_valid low), other characters yield none. The first '=' of a
// string stops decoding until the final character, which resets the decoder
// for the next string. Items are taken one per cycle as long as the result
// side keeps up: the result register holds the results of one item and sends
// them one per cycle while out_ready is high, so an item with results waits
// only while an earlier group is still being sent. An accepted item passes the
// input register and then the result register before its first result.
module base64_stream_decoder (
  input  logic       clk,
  input  logic       rst,
  // character items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       final_char,
  // result items
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       run_last,
  output logic       stream_end,
  output logic       stray_bits,
  output logic       dangling_char,
  output logic       bad_char_seen
);

  // input register
  logic       ir_valid;
  logic [7:0] ir_char;
  logic       ir_final;

  // decoder state
  b64d_pkg::b64d_state_t st;
  b64d_pkg::b64d_state_t st_next;

  // result register
  b64d_pkg::b64d_group_t grp;
  b64d_pkg::b64d_group_t grp_next;
  logic                  grp_valid;
  logic [1:0]            idx;

  logic produces;
  logic grp_last;
  logic grp_free;
  logic advance;

  b64d_step u_step (
    .st         (st),
    .char_code  (ir_char),
    .final_char (ir_final),
    .st_next    (st_next),
    .grp        (grp_next),
    .produces   (produces)
  );

  // the current result is the last of the held group
  assign grp_last = (idx == grp.n_res - 2'd1);
  assign grp_free = !grp_valid || (out_ready && grp_last);
  // an item that causes no result never waits on the result side
  assign advance  = ir_valid && (!produces || grp_free);
  assign in_ready = !ir_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ready) begin
      ir_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      ir_char  <= char_code;
      ir_final <= final_char;
    end
  end

  // decoder state moves on each time an item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register, sent one result per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (advance && produces) begin
      grp_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (grp_valid && out_ready) begin
      if (grp_last) begin
        grp_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
    if (advance && produces) grp <= grp_next;
  end

  always_comb begin
    case (idx)
      2'd0:    data_byte = grp.bytes[0];
      2'd1:    data_byte = grp.bytes[1];
      2'd2:    data_byte = grp.bytes[2];
      default: data_byte = 8'd0;
    endcase
    // flag-only result carries a zero byte
    if (!grp.has_bytes) data_byte = 8'd0;
  end

  assign out_valid     = grp_valid;
  assign byte_valid    = grp.has_bytes;
  assign run_last      = grp_last;
  assign stream_end    = grp.fin;
  assign stray_bits    = grp.stray;
  assign dangling_char = grp.dangling;
  assign bad_char_seen = grp.bad;

endmodule

FILE: rtl/core/b64d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker: port checks of the base64 stream decoder
// watches the result channel and its flags over time
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] char_code,
  input logic       final_char,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic       byte_valid,
  input logic       run_last,
  input logic       stream_end,
  input logic       stray_bits,
  input logic       dangling_char,
  input logic       bad_char_seen
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(run_last))
    else $error("stalled result changed");

  // a flag-only result closes a string and stands alone
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> run_last && stream_end && data_byte == 8'd0)
    else $error("flag-only result malformed");

  // tail flags only on results of the final character
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (stray_bits || dangling_char) |-> stream_end)
    else $error("tail flag outside final results");

  // a single held sextet yields no byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && dangling_char |-> !byte_valid && !stray_bits)
    else $error("dangling tail with byte");

  // within a group, results after a taken non-last result keep the end flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid && $stable(stream_end))
    else $error("group broken before its last result");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

FILE: tb/sv/base64_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb: self-checking bench of the base64 stream decoder
// feeds base64 text one character per item, predicts the decoded bytes and
// end-of-string flags in the bench itself and checks every result item in
// order, under random idling on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;

  // no-progress limit: far above the long hold-off plus the longest bursts
  localparam int WATCHDOG_LIMIT = 2000;
  // length of the long output hold-off that fills the decoder up
  localparam int HOLD_CYCLES    = 80;
  // extra cycles after the last expected result
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 90;
  localparam int QUIET_ITEMS    = 30;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;  // '0'

  // shapes of random strings
  typedef enum int {
    STR_CLEAN,
    STR_NOISE,
    STR_PADDED,
    STR_BAD_CHAR,
    STR_UNTERMINATED
  } string_kind_t;

  // one decoded result item as the bench expects it
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last_of_item;
    logic       at_end;
    logic       stray;
    logic       dangling;
    logic       bad;
  } decoded_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_code;
  logic       final_char;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       run_last;
  logic       stream_end;
  logic       stray_bits;
  logic       dangling_char;
  logic       bad_char_seen;

  // bench copy of the decoder state
  logic [7:0] held_sx [3];
  logic [1:0] held_n;
  logic       pad_seen;
  logic       bad_flag;

  // decoded results still to come, oldest first
  decoded_t   decoded_q[$];

  int         mismatches  = 0;
  int         items_sent  = 0;
  int         quiet_cycles = 0;
  bit         idle_on;
  bit         hold_req;

  base64_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .final_char    (final_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .run_last      (run_last),
    .stream_end    (stream_end),
    .stray_bits    (stray_bits),
    .dangling_char (dangling_char),
    .bad_char_seen (bad_char_seen)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  task automatic clear_decoder();
    held_sx[0] = 8'd0;
    held_sx[1] = 8'd0;
    held_sx[2] = 8'd0;
    held_n     = 2'd0;
    pad_seen   = 1'b0;
    bad_flag   = 1'b0;
  endtask

  // comparison chain: {bad, sextet code}, codes wrap mod 256
  function automatic logic [8:0] map_sextet(input logic [7:0] c);
    if (c == b64d_pkg::CHAR_PLUS)
      return {1'b0, b64d_pkg::SEXTET_PLUS};
    else if (c == b64d_pkg::CHAR_SLASH)
      return {1'b0, b64d_pkg::SEXTET_SLASH};
    else if (c <= b64d_pkg::CHAR_NINE)
      return {1'b0, 8'(c + b64d_pkg::DIGIT_ADD)};
    else if (c <= b64d_pkg::CHAR_UPPER_Z)
      return {1'b0, 8'(c - b64d_pkg::CHAR_UPPER_A)};
    else if (c <= b64d_pkg::CHAR_LOWER_Z)
      return {1'b0, 8'(c - b64d_pkg::LOWER_SUB)};
    else
      return {1'b1, 8'd0};
  endfunction

  // works out the results of one accepted character and queues them
  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [8:0] mapped;
    logic [7:0] sx;
    logic [7:0] bytes [3];
    int         nb;
    logic       stray;
    logic       dang;
    nb    = 0;
    stray = 1'b0;
    dang  = 1'b0;
    if (!pad_seen) begin
      if (c == b64d_pkg::CHAR_PAD) begin
        // first padding sign stops decoding for the rest of the string
        pad_seen = 1'b1;
      end else begin
        mapped = map_sextet(c);
        sx     = mapped[7:0];
        if (mapped[8]) bad_flag = 1'b1;
        if (held_n == 2'd3) begin
          // fourth sextet completes a quad
          bytes[0] = 8'((held_sx[0] << 2) | (held_sx[1] >> 4));
          bytes[1] = 8'(((held_sx[1] & 8'h0f) << 4) | (held_sx[2] >> 2));
          bytes[2] = 8'(((held_sx[2] & 8'h03) << 6) | sx);
          nb       = 3;
          held_n   = 2'd0;
        end else begin
          held_sx[held_n] = sx;
          held_n          = held_n + 2'd1;
        end
      end
    end
    // tail of the string on the final character
    if (fin && nb == 0) begin
      if (held_n == 2'd1) begin
        dang = 1'b1;
      end else if (held_n == 2'd2) begin
        bytes[0] = 8'((held_sx[0] << 2) | (held_sx[1] >> 4));
        nb       = 1;
        stray    = (held_sx[1] & 8'h0f) != 8'd0;
      end else if (held_n == 2'd3) begin
        bytes[0] = 8'((held_sx[0] << 2) | (held_sx[1] >> 4));
        bytes[1] = 8'(((held_sx[1] & 8'h0f) << 4) | (held_sx[2] >> 2));
        nb       = 2;
        stray    = (held_sx[2] & 8'h03) != 8'd0;
      end
    end
    if (nb > 0) begin
      for (int k = 0; k < nb; k++)
        decoded_q.push_back(decoded_t'{bytes[k], 1'b1, (k == nb - 1), fin,
                                       stray, dang, bad_flag});
    end else if (fin) begin
      // flag-only result when the final character yields no byte
      decoded_q.push_back(decoded_t'{8'd0, 1'b0, 1'b1, 1'b1, stray, dang, bad_flag});
    end
    if (fin) clear_decoder();
  endtask

  // ------------------------------------------------------------------ sender

  // offers one character, waits for the handshake, then predicts
  task automatic send_char(input logic [7:0] c, input logic fin);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    char_code  <= c;
    final_char <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_char(c, fin);
    items_sent++;
  endtask

  // a whole string, final flag on its last character
  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++)
      send_char(txt[i], i == txt.len() - 1);
  endtask

  function automatic logic [7:0] alpha_char();
    int idx;
    idx = $urandom_range(0, 63);
    if (idx < 26)      return 8'(b64d_pkg::CHAR_UPPER_A + idx);
    else if (idx < 52) return 8'(CHAR_LOWER_A + idx - 26);
    else if (idx < 62) return 8'(CHAR_DIGIT_0 + idx - 52);
    else if (idx == 62) return b64d_pkg::CHAR_PLUS;
    else               return b64d_pkg::CHAR_SLASH;
  endfunction

  // mostly well-formed strings with random content, some noise and breakage
  task automatic send_random_strings(input int n_items, input bit allow_idle);
    int           target;
    int           len;
    int           pick;
    string_kind_t kind;
    logic [7:0]   c;
    logic         fin;
    target = items_sent + n_items;
    while (items_sent < target) begin
      len  = $urandom_range(1, 14);
      pick = $urandom_range(0, 9);
      if (pick < 4)       kind = STR_CLEAN;
      else if (pick < 6)  kind = STR_PADDED;
      else if (pick < 7)  kind = STR_BAD_CHAR;
      else if (pick < 8)  kind = STR_UNTERMINATED;
      else                kind = STR_NOISE;
      // some strings run with no idling at all
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++) begin
        c   = alpha_char();
        fin = (i == len - 1);
        case (kind)
          STR_NOISE: begin
            c   = 8'($urandom_range(0, 255));
            fin = fin || ($urandom_range(0, 9) == 0);
          end
          STR_PADDED: begin
            if (len > 2 && i >= len - 2) c = b64d_pkg::CHAR_PAD;
          end
          STR_BAD_CHAR: begin
            if ($urandom_range(0, 4) == 0)
              c = 8'($urandom_range(int'(b64d_pkg::CHAR_LOWER_Z) + 1, 255));
          end
          STR_UNTERMINATED: begin
            // string runs on into the next one
            fin = 1'b0;
          end
          default: ;
        endcase
        send_char(c, fin);
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ----------------------------------------------------------------- checker

  function automatic string fmt_result(input decoded_t r);
    return $sformatf("data %02h valid %0b last %0b end %0b stray %0b dangling %0b bad %0b",
                     r.data, r.has_byte, r.last_of_item, r.at_end, r.stray,
                     r.dangling, r.bad);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 10) $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  // each accepted result against the oldest expectation
  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (!rst && out_valid && out_ready) begin
      got = decoded_t'{data_byte, byte_valid, run_last, stream_end, stray_bits,
                       dangling_char, bad_char_seen};
      if (decoded_q.size() == 0) begin
        report_mismatch({"unexpected result: ", fmt_result(got)});
      end else begin
        want = decoded_q.pop_front();
        if (got !== want)
          report_mismatch({"mismatch: expected ", fmt_result(want),
                           " actual ", fmt_result(got)});
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without progress", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------- tests

  // full quads, the last one completed by the final character
  task automatic test_full_quads();
    send_text("AZaz");
    send_text("09+/");
  endtask

  // tails of two, three, one and zero sextets
  task automatic test_tails();
    send_text("QR=");   // two sextets, stray low bits, padding as final
    send_text("QUJ");   // three sextets, stray low bits
    send_text("Q");     // one sextet, dangling
    send_text("=");     // nothing held, flag-only result
  endtask

  // out-of-alphabet codes before the padding sign, ignored codes after it, and a lone out-of-alphabet final character
  task automatic test_padding_and_bad();
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(b64d_pkg::CHAR_PAD, 1'b0);
    send_char(8'h80, 1'b1);
    send_text("QQ=");
    send_char(8'hff, 1'b1);
  endtask

  task automatic test_random_strings();
    send_random_strings(RANDOM_ITEMS, 1'b1);
  endtask

  // output held off while full quads keep coming, so the input stalls
  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_char(alpha_char(), i == 23);
  endtask

  // last stretch with no idling on either side
  task automatic test_quiet_tail();
    send_random_strings(QUIET_ITEMS, 1'b0);
  endtask

  // -------------------------------------------------------------------- main

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    char_code  <= 8'd0;
    final_char <= 1'b0;
    hold_req   = 1'b0;
    idle_on    = 1'b1;
    clear_decoder();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_full_quads();
    test_tails();
    test_padding_and_bad();
    test_random_strings();
    test_backpressure();
    test_quiet_tail();

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_step.sv
rtl/core/base64_stream_decoder.sv
rtl/core/b64d_checker.sv
tb/sv/base64_stream_decoder_tb.sv
